FILE: src/cpualu_pkg.sv
// Package for the CPU ALU: operation codes and the flag register type.
package cpualu_pkg;

   localparam int unsigned ModeWidth = 5;

   typedef enum logic [ModeWidth-1:0] {
      MODE_ADD     = 5'd0,
      MODE_ADDPAIR = 5'd1,
      MODE_ADC     = 5'd2,
      MODE_SUB     = 5'd3,
      MODE_SBC     = 5'd4,
      MODE_AND     = 5'd5,
      MODE_OR      = 5'd6,
      MODE_XOR     = 5'd7,
      MODE_CP      = 5'd8,
      MODE_INC     = 5'd9,
      MODE_DEC     = 5'd10,
      MODE_CCF     = 5'd11,
      MODE_SCF     = 5'd12,
      MODE_RRA     = 5'd13,
      MODE_RLA     = 5'd14,
      MODE_RRCA    = 5'd15,
      MODE_RLCA    = 5'd16,
      MODE_CPL     = 5'd17,
      MODE_BITTEST = 5'd18,
      MODE_RES     = 5'd19,
      MODE_SET     = 5'd20,
      MODE_SRL     = 5'd21,
      MODE_RR      = 5'd22,
      MODE_RL      = 5'd23,
      MODE_RRC     = 5'd24,
      MODE_RLC     = 5'd25,
      MODE_SRA     = 5'd26,
      MODE_SLA     = 5'd27,
      MODE_SWAP    = 5'd28
   } mode_type;

   typedef struct packed {
      logic zero;
      logic subtract;
      logic half;
      logic carry;
   } flags_type;

endpackage

FILE: src/cpu_alu_with_flags.sv
// Top level of the CPU ALU: input register, operation logic, flag register, result register.
//
//   Channel  Ports   Direction  Beat contents
//   request  req_*   in         mode, operand_a, operand_b, bit_index, pair_value, pair_addend
//   response rsp_*   out        result_byte, result_word, zero/subtract/half/carry flags
//
// Each beat is held in the input register and is then computed into the result
// register, from which the response is offered.
// A new beat is accepted in every cycle while the response side takes results; the rate is
// one beat per cycle, set by the single pass through the operation logic.
// The kept flags are updated as a beat moves into the result register, so the next beat
// reads the carry left by the previous one. Synchronous reset clears the flags and both
// valid bits. When the response is stalled, the input register holds one more beat.
module cpu_alu_with_flags
   import cpualu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_mode,
   input  logic [7:0]  req_operand_a,
   input  logic [7:0]  req_operand_b,
   input  logic [2:0]  req_bit_index,
   input  logic [15:0] req_pair_value,
   input  logic [15:0] req_pair_addend,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_result_byte,
   output logic [15:0] rsp_result_word,
   output logic        rsp_zero_out,
   output logic        rsp_subtract_out,
   output logic        rsp_half_out,
   output logic        rsp_carry_out
);

   // Input register stage.
   logic        s1_valid_ff;
   logic [4:0]  s1_mode_ff;
   logic [7:0]  s1_a_ff;
   logic [7:0]  s1_b_ff;
   logic [2:0]  s1_bit_ff;
   logic [15:0] s1_pv_ff;
   logic [15:0] s1_pa_ff;

   // Kept flags and result register stage.
   flags_type   flags_ff;
   flags_type   flags_in;
   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   logic [7:0]  out_byte_in;
   logic [15:0] out_word_ff;
   logic [15:0] out_word_in;

   logic out_free;
   logic s1_move;
   logic req_take;

   // The result register can be loaded when it is empty or being emptied this cycle.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_take  = req_valid && req_ready;

   // Operation logic.
   logic       cin;
   logic [8:0] add_sum;
   logic [8:0] sub_diff;
   logic [16:0] pair_sum;
   logic [7:0] inc_val;
   logic [7:0] dec_val;
   logic [7:0] bit_mask;

   assign cin      = flags_ff.carry;
   assign add_sum  = {1'b0, s1_a_ff} + {1'b0, s1_b_ff}
                   + {8'd0, (mode_type'(s1_mode_ff) == MODE_ADC) & cin};
   // Bit eight of the nine-bit difference is the borrow.
   assign sub_diff = {1'b0, s1_a_ff} - {1'b0, s1_b_ff}
                   - {8'd0, (mode_type'(s1_mode_ff) == MODE_SBC) & cin};
   assign pair_sum = {1'b0, s1_pv_ff} + {1'b0, s1_pa_ff};
   assign inc_val  = s1_a_ff + 8'd1;
   assign dec_val  = s1_a_ff - 8'd1;
   assign bit_mask = 8'd1 << s1_bit_ff;

   always_comb begin
      logic [7:0] r;
      r           = s1_a_ff;
      flags_in    = flags_ff;
      out_word_in = s1_pv_ff;
      unique case (mode_type'(s1_mode_ff))
         MODE_ADD, MODE_ADC: begin
            r        = add_sum[7:0];
            flags_in = '{zero: (r == 8'd0), subtract: 1'b0,
                         half: s1_a_ff[4] ^ s1_b_ff[4] ^ r[4], carry: add_sum[8]};
         end
         MODE_ADDPAIR: begin
            out_word_in       = pair_sum[15:0];
            flags_in.subtract = 1'b0;
            flags_in.half     = s1_pv_ff[12] ^ s1_pa_ff[12] ^ pair_sum[12];
            flags_in.carry    = pair_sum[16];
         end
         MODE_SUB, MODE_SBC, MODE_CP: begin
            // Compare sets the flags of a subtract but leaves the value alone.
            if (mode_type'(s1_mode_ff) != MODE_CP) begin
               r = sub_diff[7:0];
            end
            flags_in = '{zero: (sub_diff[7:0] == 8'd0), subtract: 1'b1,
                         half: s1_a_ff[4] ^ s1_b_ff[4] ^ sub_diff[4], carry: sub_diff[8]};
         end
         MODE_AND: begin
            r        = s1_a_ff & s1_b_ff;
            flags_in = '{zero: (r == 8'd0), subtract: 1'b0, half: 1'b1, carry: 1'b0};
         end
         MODE_OR: begin
            r        = s1_a_ff | s1_b_ff;
            flags_in = '{zero: (r == 8'd0), subtract: 1'b0, half: 1'b0, carry: 1'b0};
         end
         MODE_XOR: begin
            r        = s1_a_ff ^ s1_b_ff;
            flags_in = '{zero: (r == 8'd0), subtract: 1'b0, half: 1'b0, carry: 1'b0};
         end
         MODE_INC, MODE_DEC: begin
            r = (mode_type'(s1_mode_ff) == MODE_INC) ? inc_val : dec_val;
            flags_in.zero     = (r == 8'd0);
            flags_in.subtract = (mode_type'(s1_mode_ff) == MODE_DEC);
            flags_in.half     = s1_a_ff[4] ^ r[4];
         end
         MODE_CCF: begin
            flags_in.subtract = 1'b0;
            flags_in.half     = 1'b0;
            flags_in.carry    = !cin;
         end
         MODE_SCF: begin
            flags_in.subtract = 1'b0;
            flags_in.half     = 1'b0;
            flags_in.carry    = 1'b1;
         end
         // Accumulator rotates always clear the zero flag.
         MODE_RRA: begin
            r        = {cin, s1_a_ff[7:1]};
            flags_in = '{zero: 1'b0, subtract: 1'b0, half: 1'b0, carry: s1_a_ff[0]};
         end
         MODE_RLA: begin
            r        = {s1_a_ff[6:0], cin};
            flags_in = '{zero: 1'b0, subtract: 1'b0, half: 1'b0, carry: s1_a_ff[7]};
         end
         MODE_RRCA: begin
            r        = {s1_a_ff[0], s1_a_ff[7:1]};
            flags_in = '{zero: 1'b0, subtract: 1'b0, half: 1'b0, carry: s1_a_ff[0]};
         end
         MODE_RLCA: begin
            r        = {s1_a_ff[6:0], s1_a_ff[7]};
            flags_in = '{zero: 1'b0, subtract: 1'b0, half: 1'b0, carry: s1_a_ff[7]};
         end
         MODE_CPL: begin
            r                 = ~s1_a_ff;
            flags_in.subtract = 1'b1;
            flags_in.half     = 1'b1;
         end
         MODE_BITTEST: begin
            flags_in.zero     = !s1_a_ff[s1_bit_ff];
            flags_in.subtract = 1'b0;
            flags_in.half     = 1'b1;
         end
         MODE_RES: r = s1_a_ff & ~bit_mask;
         MODE_SET: r = s1_a_ff | bit_mask;
         MODE_SRL: begin
            r        = {1'b0, s1_a_ff[7:1]};
            flags_in = '{zero: (r == 8'd0), subtract: 1'b0, half: 1'b0, carry: s1_a_ff[0]};
         end
         MODE_RR: begin
            r        = {cin, s1_a_ff[7:1]};
            flags_in = '{zero: (r == 8'd0), subtract: 1'b0, half: 1'b0, carry: s1_a_ff[0]};
         end
         MODE_RL: begin
            r        = {s1_a_ff[6:0], cin};
            flags_in = '{zero: (r == 8'd0), subtract: 1'b0, half: 1'b0, carry: s1_a_ff[7]};
         end
         MODE_RRC: begin
            r        = {s1_a_ff[0], s1_a_ff[7:1]};
            flags_in = '{zero: (r == 8'd0), subtract: 1'b0, half: 1'b0, carry: s1_a_ff[0]};
         end
         MODE_RLC: begin
            r        = {s1_a_ff[6:0], s1_a_ff[7]};
            flags_in = '{zero: (r == 8'd0), subtract: 1'b0, half: 1'b0, carry: s1_a_ff[7]};
         end
         MODE_SRA: begin
            r        = {s1_a_ff[7], s1_a_ff[7:1]};
            flags_in = '{zero: (r == 8'd0), subtract: 1'b0, half: 1'b0, carry: s1_a_ff[0]};
         end
         MODE_SLA: begin
            r        = {s1_a_ff[6:0], 1'b0};
            flags_in = '{zero: (r == 8'd0), subtract: 1'b0, half: 1'b0, carry: s1_a_ff[7]};
         end
         MODE_SWAP: begin
            r        = {s1_a_ff[3:0], s1_a_ff[7:4]};
            flags_in = '{zero: (r == 8'd0), subtract: 1'b0, half: 1'b0, carry: 1'b0};
         end
         // Unused codes pass the operands through and keep every flag.
         default: r = s1_a_ff;
      endcase
      out_byte_in = r;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (out_free) begin
            out_valid_ff <= s1_valid_ff;
         end
         if (s1_move) begin
            flags_ff <= flags_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff <= req_mode;
         s1_a_ff    <= req_operand_a;
         s1_b_ff    <= req_operand_b;
         s1_bit_ff  <= req_bit_index;
         s1_pv_ff   <= req_pair_value;
         s1_pa_ff   <= req_pair_addend;
      end
      if (s1_move) begin
         out_byte_ff <= out_byte_in;
         out_word_ff <= out_word_in;
      end
   end

   // The flag outputs show the kept flags, which change only when a new result is loaded.
   assign rsp_valid        = out_valid_ff;
   assign rsp_result_byte  = out_byte_ff;
   assign rsp_result_word  = out_word_ff;
   assign rsp_zero_out     = flags_ff.zero;
   assign rsp_subtract_out = flags_ff.subtract;
   assign rsp_half_out     = flags_ff.half;
   assign rsp_carry_out    = flags_ff.carry;

endmodule

FILE: sim/alu_check_pkg.sv
`timescale 1ns / 100ps
// Scoreboard class for the CPU ALU bench: flag-keeping predictor and queue of pending results.
package alu_check_pkg;
   import cpualu_pkg::*;

   typedef struct packed {
      logic [4:0]  mode;
      logic [7:0]  operand_a;
      logic [7:0]  operand_b;
      logic [2:0]  bit_index;
      logic [15:0] pair_value;
      logic [15:0] pair_addend;
   } alu_request_type;

   typedef struct packed {
      logic [7:0]  result_byte;
      logic [15:0] result_word;
      flags_type   flags;
   } alu_result_type;

   class alu_scoreboard;
      flags_type      kept_flags;
      alu_result_type pending_results[$];
      int unsigned    mismatches;
      int unsigned    requests_noted;
      int unsigned    results_checked;
      logic [31:0]    modes_seen;

      function new();
         kept_flags      = '0;
         mismatches      = 0;
         requests_noted  = 0;
         results_checked = 0;
         modes_seen      = '0;
      endfunction

      // Computes one operation and updates the kept flags, as the block does.
      function alu_result_type alu_execute(alu_request_type rq);
         alu_result_type rs;
         flags_type      nf;
         logic [7:0]     a;
         logic [7:0]     r;
         logic [7:0]     mix;
         logic [15:0]    mix16;
         logic [8:0]     sum9;
         logic [16:0]    sum17;
         logic [15:0]    diff;
         logic           cin;
         a              = rq.operand_a;
         r              = a;
         rs.result_word = rq.pair_value;
         nf             = kept_flags;
         cin            = kept_flags.carry;
         case (rq.mode)
            MODE_ADD, MODE_ADC: begin
               sum9 = 9'(a) + 9'(rq.operand_b) + 9'((rq.mode == MODE_ADC) & cin);
               r    = sum9[7:0];
               mix  = a ^ rq.operand_b ^ r;
               nf   = {r == 8'h00, 1'b0, mix[4], sum9[8]};
            end
            MODE_ADDPAIR: begin
               sum17          = 17'(rq.pair_value) + 17'(rq.pair_addend);
               rs.result_word = sum17[15:0];
               mix16          = rq.pair_value ^ rq.pair_addend ^ sum17[15:0];
               nf.subtract    = 1'b0;
               nf.half        = mix16[12];
               nf.carry       = sum17[16];
            end
            MODE_SUB, MODE_SBC, MODE_CP: begin
               diff = 16'(a) - 16'(rq.operand_b) - 16'((rq.mode == MODE_SBC) & cin);
               if (rq.mode != MODE_CP) begin
                  r = diff[7:0];
               end
               mix = a ^ rq.operand_b ^ diff[7:0];
               nf  = {diff[7:0] == 8'h00, 1'b1, mix[4], diff[15:8] != 8'h00};
            end
            MODE_AND: begin
               r  = a & rq.operand_b;
               nf = {r == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            MODE_OR: begin
               r  = a | rq.operand_b;
               nf = {r == 8'h00, 3'b000};
            end
            MODE_XOR: begin
               r  = a ^ rq.operand_b;
               nf = {r == 8'h00, 3'b000};
            end
            MODE_INC, MODE_DEC: begin
               r           = (rq.mode == MODE_INC) ? a + 8'd1 : a - 8'd1;
               mix         = a ^ 8'h01 ^ r;
               nf.zero     = (r == 8'h00);
               nf.subtract = (rq.mode == MODE_DEC);
               nf.half     = mix[4];
            end
            MODE_CCF: begin
               nf.subtract = 1'b0;
               nf.half     = 1'b0;
               nf.carry    = ~cin;
            end
            MODE_SCF: begin
               nf.subtract = 1'b0;
               nf.half     = 1'b0;
               nf.carry    = 1'b1;
            end
            // The accumulator rotates always clear the zero flag.
            MODE_RRA: begin
               r  = {cin, a[7:1]};
               nf = {3'b000, a[0]};
            end
            MODE_RLA: begin
               r  = {a[6:0], cin};
               nf = {3'b000, a[7]};
            end
            MODE_RRCA: begin
               r  = {a[0], a[7:1]};
               nf = {3'b000, a[0]};
            end
            MODE_RLCA: begin
               r  = {a[6:0], a[7]};
               nf = {3'b000, a[7]};
            end
            MODE_CPL: begin
               r           = ~a;
               nf.subtract = 1'b1;
               nf.half     = 1'b1;
            end
            MODE_BITTEST: begin
               nf.zero     = ~a[rq.bit_index];
               nf.subtract = 1'b0;
               nf.half     = 1'b1;
            end
            MODE_RES: begin
               r = a & ~(8'h01 << rq.bit_index);
            end
            MODE_SET: begin
               r = a | (8'h01 << rq.bit_index);
            end
            MODE_SRL: begin
               r  = {1'b0, a[7:1]};
               nf = {r == 8'h00, 2'b00, a[0]};
            end
            MODE_RR: begin
               r  = {cin, a[7:1]};
               nf = {r == 8'h00, 2'b00, a[0]};
            end
            MODE_RL: begin
               r  = {a[6:0], cin};
               nf = {r == 8'h00, 2'b00, a[7]};
            end
            MODE_RRC: begin
               r  = {a[0], a[7:1]};
               nf = {r == 8'h00, 2'b00, a[0]};
            end
            MODE_RLC: begin
               r  = {a[6:0], a[7]};
               nf = {r == 8'h00, 2'b00, a[7]};
            end
            MODE_SRA: begin
               r  = {a[7], a[7:1]};
               nf = {r == 8'h00, 2'b00, a[0]};
            end
            MODE_SLA: begin
               r  = {a[6:0], 1'b0};
               nf = {r == 8'h00, 2'b00, a[7]};
            end
            MODE_SWAP: begin
               r  = {a[3:0], a[7:4]};
               nf = {r == 8'h00, 3'b000};
            end
            default: begin
            end
         endcase
         kept_flags     = nf;
         rs.result_byte = r;
         rs.flags       = nf;
         return rs;
      endfunction

      function void note_request(alu_request_type rq);
         pending_results.push_back(alu_execute(rq));
         requests_noted++;
         modes_seen[rq.mode] = 1'b1;
      endfunction

      task report_mismatch(string text);
         $display("MISMATCH at response %0d: %s", results_checked, text);
         mismatches++;
      endtask

      task compare_field(string name, int unsigned got, int unsigned want);
         if (got != want) begin
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
         end
      endtask

      task check_result(alu_result_type got);
         alu_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("response beat with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            compare_field("result_byte", got.result_byte, want.result_byte);
            compare_field("result_word", got.result_word, want.result_word);
            compare_field("zero", got.flags.zero, want.flags.zero);
            compare_field("subtract", got.flags.subtract, want.flags.subtract);
            compare_field("half", got.flags.half, want.flags.half);
            compare_field("carry", got.flags.carry, want.flags.carry);
         end
         results_checked++;
      endtask

      function int unsigned pending();
         return pending_results.size();
      endfunction
   endclass

endpackage

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Top-level bench for the CPU ALU: clock, reset, request driver, response sink and watchdog.
module testbench;
   import cpualu_pkg::*;
   import alu_check_pkg::*;

   // Mode codes 29 to 31 are not operations; the block must pass operand_a and
   // pair_value through and keep every flag.
   localparam logic [4:0] MODE_UNUSED_LO = 5'd29;
   localparam logic [4:0] MODE_UNUSED_HI = 5'd31;

   // Cycles without any beat on either channel before the run is declared hung.
   // The slowest legal stretch is a few sender gap cycles plus a run of response
   // stalls at 49 percent, which never comes close to this.
   localparam int unsigned STALL_LIMIT = 1000;
   // Further edges waited after the last response, to cover anything stray.
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned ITEMS_PER_PHASE = 410;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [4:0]  req_mode = '0;
   logic [7:0]  req_operand_a = '0;
   logic [7:0]  req_operand_b = '0;
   logic [2:0]  req_bit_index = '0;
   logic [15:0] req_pair_value = '0;
   logic [15:0] req_pair_addend = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_result_byte;
   logic [15:0] rsp_result_word;
   logic        rsp_zero_out;
   logic        rsp_subtract_out;
   logic        rsp_half_out;
   logic        rsp_carry_out;

   // Idling rates in percent, changed by the main sequence between phases.
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned quiet_cycles = 0;

   alu_scoreboard board;

   cpu_alu_with_flags dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Operand values lean on the carry and half-carry boundaries a good part of
   // the time; the rest are uniform so that every bit toggles.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h0F;
         3: return 8'h10;
         4: return ($urandom_range(1) != 0) ? 8'h80 : 8'h7F;
         default: return 8'($urandom());
      endcase
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h0FFF;
         3: return 16'h1000;
         default: return 16'($urandom());
      endcase
   endfunction

   // Drives one request beat and returns at the edge where it is accepted.
   // Valid is left high on return, so a back-to-back beat only changes the
   // payload; an idle gap first lowers valid in that same time step. Each cycle
   // the sender could offer a beat, it idles with the current percentage.
   task automatic send_op(input logic [4:0] mode, input logic [7:0] a, input logic [7:0] b,
                          input logic [2:0] bi, input logic [15:0] pv, input logic [15:0] pa);
      alu_request_type rq;
      rq = {mode, a, b, bi, pv, pa};
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_operand_a   <= a;
      req_operand_b   <= b;
      req_bit_index   <= bi;
      req_pair_value  <= pv;
      req_pair_addend <= pa;
      do @(posedge clock); while (!req_ready);
      board.note_request(rq);
   endtask

   // Response sink. The handshake is sampled at the edge, before any of this
   // edge's updates land, and ready is redrawn once per cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            board.check_result({rsp_result_byte, rsp_result_word, rsp_zero_out,
                                rsp_subtract_out, rsp_half_out, rsp_carry_out});
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Watchdog: any beat on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("FAIL cpu_alu_with_flags");
            $finish;
         end
      end
   end

   initial begin
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed beats run under the first idling mix. The order matters: the
      // flag-only operations set up the carry that the following carry-in
      // operations consume.
      req_idle_pct = 20;
      rsp_idle_pct = 49;
      send_op(MODE_SCF, 8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_ADC, 8'hFF, 8'h00, 3'd0, 16'hFFFF, 16'h0000);
      send_op(MODE_ADD, 8'hFF, 8'h01, 3'd7, 16'h0000, 16'hFFFF);
      send_op(MODE_SBC, 8'h00, 8'h00, 3'd0, 16'h1234, 16'h0000);
      send_op(MODE_SUB, 8'h80, 8'h01, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_CP, 8'h00, 8'hFF, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_ADDPAIR, 8'h00, 8'h00, 3'd0, 16'hFFFF, 16'h0001);
      send_op(MODE_ADDPAIR, 8'hFF, 8'hFF, 3'd7, 16'h0FFF, 16'h0001);
      send_op(MODE_AND, 8'hFF, 8'h00, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_OR, 8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_XOR, 8'hFF, 8'hFF, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_INC, 8'hFF, 8'h00, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_DEC, 8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_CCF, 8'h55, 8'h00, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_RRA, 8'h01, 8'h00, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_RLA, 8'h80, 8'h00, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_RRCA, 8'h01, 8'h00, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_RLCA, 8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_CPL, 8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_BITTEST, 8'h7F, 8'h00, 3'd7, 16'h0000, 16'h0000);
      send_op(MODE_RES, 8'hFF, 8'h00, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_SET, 8'h00, 8'h00, 3'd7, 16'h0000, 16'h0000);
      send_op(MODE_SRL, 8'h01, 8'h00, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_RR, 8'h01, 8'h00, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_RL, 8'h80, 8'h00, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_RRC, 8'h00, 8'h00, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_RLC, 8'hFF, 8'h00, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_SRA, 8'h80, 8'h00, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_SLA, 8'h80, 8'h00, 3'd0, 16'h0000, 16'h0000);
      // Swap must clear a carry that the shift before it left set.
      send_op(MODE_SWAP, 8'hF0, 8'h00, 3'd0, 16'h0000, 16'h0000);
      send_op(MODE_UNUSED_HI, 8'hA5, 8'h5A, 3'd3, 16'hBEEF, 16'h1111);
      send_op(MODE_UNUSED_LO, 8'h00, 8'hFF, 3'd4, 16'h0000, 16'hFFFF);

      // Random beats in three idling mixes: sender light and receiver heavy,
      // then the reverse, then both sides at full rate. All 32 mode codes are
      // drawn, so the carry chain between operations is exercised at random.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 20;
               rsp_idle_pct = 49;
            end
            1: begin
               req_idle_pct = 49;
               rsp_idle_pct = 20;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         repeat (ITEMS_PER_PHASE) begin
            send_op(5'($urandom_range(31)), pick_byte(), pick_byte(),
                    3'($urandom_range(7)), pick_word(), pick_word());
         end
      end
      req_valid <= 1'b0;

      // Drain: every expected response must arrive; the watchdog bounds this.
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d request beats over %0d of 32 mode codes in three idling mixes.",
               board.requests_noted, $countones(board.modes_seen));
      $display("%0d response beats compared field by field, %0d mismatches.",
               board.results_checked, board.mismatches);
      if (board.mismatches == 0) begin
         $display("PASS cpu_alu_with_flags");
      end else begin
         $display("FAIL cpu_alu_with_flags");
      end
      $finish;
   end

endmodule
